/* hw/rtl/pmsr_pkg.sv */
`default_nettype none

package pmsr_pkg;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_BYTE    = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_HDR   = 2'd1,
    ST_BAD_SUM   = 2'd2,
    ST_TIMEOUT   = 2'd3
  } status_t;

  localparam logic [3:0] FRAME_LEN     = 4'd9;
  localparam logic [3:0] SUM_LAST      = 4'd7;
  localparam logic [3:0] CHECK_POS     = 4'd8;
  localparam logic [3:0] PAYLOAD_FIRST = 4'd2;
  localparam logic [7:0] FRAME_HEADER  = 8'hFF;
  localparam logic [3:0] LIMIT_RESET   = 4'd2;

  // Outcome of the closing byte of a frame.
  typedef struct packed {
    logic        done;
    logic        hdr_bad;
    logic        sum_bad;
    logic [47:0] payload;
  } frame_res_t;

endpackage

`default_nettype wire

/* hw/rtl/pmsr_frame.sv */
`default_nettype none

module pmsr_frame (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire pmsr_pkg::opcode_t   opcode,
  input  wire logic [7:0]          rx_byte,
  output pmsr_pkg::frame_res_t     res
);

  logic [3:0]  byte_position;
  logic [7:0]  running_sum;
  logic        header_good;
  logic [47:0] payload_bytes;

  logic        byte_take;
  logic [7:0]  sum_check;

  assign byte_take = accept && (opcode == pmsr_pkg::OP_BYTE) &&
                     (byte_position < pmsr_pkg::FRAME_LEN);

  // The check byte is good when it brings the running sum back to zero.
  assign sum_check = running_sum + rx_byte;

  always_comb begin
    res.done    = byte_take && (byte_position == pmsr_pkg::CHECK_POS);
    res.hdr_bad = !header_good;
    res.sum_bad = (sum_check != 8'd0);
    res.payload = payload_bytes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= pmsr_pkg::FRAME_LEN;
      running_sum   <= 8'd0;
      header_good   <= 1'b0;
      payload_bytes <= 48'd0;
    end else if (accept) begin
      unique case (opcode)
        pmsr_pkg::OP_REQUEST: begin
          byte_position <= 4'd0;
          running_sum   <= 8'd0;
          header_good   <= 1'b0;
          payload_bytes <= 48'd0;
        end
        pmsr_pkg::OP_TIMEOUT: begin
          byte_position <= pmsr_pkg::FRAME_LEN;
        end
        pmsr_pkg::OP_BYTE: begin
          if (byte_take) begin
            if (byte_position == 4'd0) begin
              header_good <= (rx_byte == pmsr_pkg::FRAME_HEADER);
            end else if (byte_position <= pmsr_pkg::SUM_LAST) begin
              running_sum <= sum_check;
              if (byte_position >= pmsr_pkg::PAYLOAD_FIRST) begin
                payload_bytes <= {payload_bytes[39:0], rx_byte};
              end
            end
            if (byte_position == pmsr_pkg::CHECK_POS) begin
              byte_position <= pmsr_pkg::FRAME_LEN;
            end else begin
              byte_position <= byte_position + 4'd1;
            end
          end
        end
        pmsr_pkg::OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pm_sensor_response_frame_checker.sv */
`default_nettype none

// Channel  Direction  Handshake              Word
// cfg      in         cfg_valid/cfg_ready    error_limit
// in       in         in_valid/in_ready      opcode, rx_byte
// out      out        out_valid/out_ready    status, pm2_5_value, pm10_value,
//                                            pm1_value, reinit_needed, error_count
//
// Each input word is handled in the cycle it is accepted; its result, if any,
// appears in the output register on the next cycle. One word per cycle is
// taken while the output register is empty or being drained.
// A stalled output blocks input only while the held result is not taken.
// Synchronous reset closes the frame, clears the timeout counter and sets
// the error limit register to 2. cfg_ready is always high.

module pm_sensor_response_frame_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  error_limit,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [15:0]      pm2_5_value,
  output logic [15:0]      pm10_value,
  output logic [15:0]      pm1_value,
  output logic             reinit_needed,
  output logic [4:0]       error_count
);

  logic                  in_fire;
  pmsr_pkg::opcode_t     op;
  pmsr_pkg::frame_res_t  frame;

  logic [3:0]            limit;
  logic [4:0]            timeout_count;
  logic [4:0]            timeout_count_next;
  logic                  emit;
  pmsr_pkg::status_t     status_next;
  logic [47:0]           payload_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign op        = pmsr_pkg::opcode_t'(opcode);

  pmsr_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_fire),
    .opcode  (op),
    .rx_byte (rx_byte),
    .res     (frame)
  );

  always_comb begin
    timeout_count_next = timeout_count;
    emit               = 1'b0;
    status_next        = pmsr_pkg::ST_OK;
    payload_next       = 48'd0;
    if (in_fire && (op == pmsr_pkg::OP_TIMEOUT)) begin
      emit        = 1'b1;
      status_next = pmsr_pkg::ST_TIMEOUT;
      // Saturates one above the limit.
      if (timeout_count <= {1'b0, limit}) begin
        timeout_count_next = timeout_count + 5'd1;
      end
    end else if (frame.done) begin
      emit = 1'b1;
      priority if (frame.hdr_bad) begin
        status_next = pmsr_pkg::ST_BAD_HDR;
      end else if (frame.sum_bad) begin
        status_next = pmsr_pkg::ST_BAD_SUM;
      end else begin
        status_next        = pmsr_pkg::ST_OK;
        payload_next       = frame.payload;
        timeout_count_next = 5'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit         <= pmsr_pkg::LIMIT_RESET;
      timeout_count <= 5'd0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= error_limit;
      end
      timeout_count <= timeout_count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status        <= status_next;
      pm2_5_value   <= payload_next[47:32];
      pm10_value    <= payload_next[31:16];
      pm1_value     <= payload_next[15:0];
      reinit_needed <= (timeout_count_next > {1'b0, limit});
      error_count   <= timeout_count_next;
    end
  end

  a_timeout_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && (op == pmsr_pkg::OP_TIMEOUT) |=>
      out_valid && (status == pmsr_pkg::ST_TIMEOUT))
    else $error("timeout word gave no timeout result");

  a_ok_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == pmsr_pkg::ST_OK) |-> (error_count == 5'd0))
    else $error("good frame did not clear the error count");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != pmsr_pkg::ST_OK) |->
      (pm2_5_value == 16'd0) && (pm10_value == 16'd0) && (pm1_value == 16'd0))
    else $error("readings not zero on a failed result");

  a_request_silent: assert property (@(posedge clk) disable iff (rst)
    in_fire && (op == pmsr_pkg::OP_REQUEST) |=> (out_valid == $past(out_valid && !out_ready)))
    else $error("request word produced a result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    timeout_count <= 5'd16)
    else $error("timeout count beyond saturation");

endmodule

`default_nettype wire
